>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/gda_pkg.sv
// Types, constants and calendar helpers for the date adder.
package gda_pkg;

	localparam int DayW   = 5;
	localparam int MonthW = 4;
	localparam int YearW  = 14;
	localparam int CountW = 15;
	// internal year grows past the field by the years skipped
	localparam int YearIW = 15;

	localparam logic [MonthW-1:0] MonJan = 4'd1;
	localparam logic [MonthW-1:0] MonFeb = 4'd2;
	localparam logic [MonthW-1:0] MonDec = 4'd12;

	// inverse of 25 modulo 2**15 and the divisibility bound
	localparam logic [YearIW-1:0] Inv25   = 15'd23593;
	localparam logic [YearIW-1:0] Lim25   = 15'(32767 / 25);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_STEP
	} gda_state_t;

	function automatic logic div25(input logic [YearIW-1:0] y);
		logic [2*YearIW-1:0] p;
		p = y * Inv25;
		return p[YearIW-1:0] <= Lim25;
	endfunction

	function automatic logic leap_year(input logic [YearIW-1:0] y);
		logic d25;
		d25 = div25(y);
		return ((y[1:0] == 2'd0) && !d25) || ((y[3:0] == 4'd0) && d25);
	endfunction

	function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
		input logic leap);
		logic [DayW-1:0] r;
		unique case (m)
			4'd2:                   r = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			default:                r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/gregorian_date_add_days.sv
// Gregorian date adder: one shared subtractor stepped under a small sequencer.
// Each request is checked, then stepped one month or one whole year skipped at a time,
// then finished once the result register is free; a bad date skips the stepping.
// One request at a time; in_stall is high from acceptance to result load,
// so the next request is taken only after the result is loaded.
// The result register lets the next request in while a result waits.
// Reset (arst_n low, asynchronous) returns the sequencer to idle, no result pending.
`include "assert_macros.svh"
module gregorian_date_add_days (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [gda_pkg::DayW-1:0]   start_day,
	input  logic [gda_pkg::MonthW-1:0] start_month,
	input  logic [gda_pkg::YearW-1:0]  start_year,
	input  logic [gda_pkg::CountW-1:0] days_to_add,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [gda_pkg::DayW-1:0]   end_day,
	output logic [gda_pkg::MonthW-1:0] end_month,
	output logic [gda_pkg::YearW-1:0]  end_year,
	output logic                       bad_date
);
	import gda_pkg::*;

	gda_state_t          st_q, st_d;
	logic [DayW-1:0]     d_q;
	logic [MonthW-1:0]   m_q;
	logic [YearIW-1:0]   y_q;
	logic [CountW-1:0]   left_q;
	logic                bad_q;
	logic                out_valid_q;
	logic [DayW-1:0]     end_day_q;
	logic [MonthW-1:0]   end_month_q;
	logic [YearW-1:0]    end_year_q;
	logic                bad_date_q;

	logic                in_acc, out_free, leap, jan1, year_skip, fits, finish;
	logic [DayW-1:0]     dim, room;
	logic [8:0]          ylen;
	logic [CountW-1:0]   amt, diff;
	logic                invalid;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign leap = leap_year(y_q);
	assign dim  = month_days(m_q, leap);
	assign room = dim - d_q;
	assign ylen = leap ? 9'd366 : 9'd365;
	assign jan1 = (m_q == MonJan) && (d_q == 5'd1);
	assign year_skip = jan1 && (left_q >= CountW'(ylen));
	// shared subtractor: a whole year or the rest of this month
	assign amt  = year_skip ? CountW'(ylen) : CountW'(room) + CountW'(1);
	assign diff = left_q - amt;
	assign fits = left_q <= CountW'(room);
	assign finish = (st_q == ST_STEP) && (left_q == '0) && out_free;
	assign invalid = (m_q < MonJan) || (m_q > MonDec) || (d_q == '0) || (d_q > dim);

	always_comb begin
		st_d     = st_q;
		in_stall = 1'b1;
		unique case (st_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) st_d = ST_CHECK;
			end
			ST_CHECK: st_d = ST_STEP;
			ST_STEP: begin
				if (finish) st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			d_q    <= start_day;
			m_q    <= start_month;
			y_q    <= YearIW'(start_year);
			left_q <= days_to_add;
			bad_q  <= 1'b0;
		end else if (st_q == ST_CHECK) begin
			if (invalid) begin
				bad_q  <= 1'b1;
				left_q <= '0;
			end
		end else if (st_q == ST_STEP && left_q != '0) begin
			if (year_skip) begin
				y_q    <= y_q + YearIW'(1);
				left_q <= diff;
			end else if (fits) begin
				d_q    <= d_q + left_q[DayW-1:0];
				left_q <= '0;
			end else begin
				left_q <= diff;
				d_q    <= 5'd1;
				if (m_q == MonDec) begin
					m_q <= MonJan;
					y_q <= y_q + YearIW'(1);
				end else begin
					m_q <= m_q + MonthW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (finish) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			end_day_q   <= d_q;
			end_month_q <= m_q;
			end_year_q  <= y_q[YearW-1:0];
			bad_date_q  <= bad_q;
		end
	end

	assign out_valid = out_valid_q;
	assign end_day   = end_day_q;
	assign end_month = end_month_q;
	assign end_year  = end_year_q;
	assign bad_date  = bad_date_q;

	`ASSERT_NEXT(a_accept_checks, clk, arst_n, in_acc, st_q == ST_CHECK)
	`ASSERT_SAME(a_step_month_ok, clk, arst_n, (st_q == ST_STEP) && !bad_q,
		(m_q >= MonJan) && (m_q <= MonDec))
	`ASSERT_SAME(a_step_day_ok, clk, arst_n, (st_q == ST_STEP) && !bad_q,
		(d_q != '0) && (d_q <= dim))
	`ASSERT_NEXT(a_finish_shows, clk, arst_n, finish, out_valid && (st_q == ST_IDLE))
endmodule
